// ===== hw/rtl/i2cbe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cbe_pkg
// shared codes, descriptor type and sizes of the i2c master byte engine
// ----------------------------------------------------------------------------
package i2cbe_pkg;

    localparam int MAX_ADDRESS_BYTES = 4;
    localparam int ADDR_W = 8 * MAX_ADDRESS_BYTES;
    localparam int BYTES_W = $clog2(MAX_ADDRESS_BYTES);

    localparam logic [2:0] OP_COMMAND = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_READ_ACK = 3'd2;
    localparam logic [2:0] OP_READ_NAK = 3'd3;
    localparam logic [2:0] OP_STOP = 3'd4;
    localparam logic [2:0] OP_SEEK = 3'd5;

    localparam logic [2:0] SYM_START = 3'd0;
    localparam logic [2:0] SYM_STOP = 3'd1;
    localparam logic [2:0] SYM_DRIVE = 3'd2;
    localparam logic [2:0] SYM_SAMPLE = 3'd3;
    localparam logic [2:0] SYM_NONE = 3'd4;

    localparam logic [1:0] STAT_OK = 2'd0;
    localparam logic [1:0] STAT_NAK = 2'd1;
    localparam logic [1:0] STAT_TIMEOUT = 2'd2;
    localparam logic [1:0] STAT_INVALID = 2'd3;

    localparam logic [0:0] REG_RETRY_LIMIT = 1'd0;
    localparam logic [0:0] REG_ADDRESS_BYTES = 1'd1;

    localparam logic [3:0] ACK_SLOT = 4'd8;

    typedef enum logic [3:0] {
        K_BYTES = 4'b0001,
        K_READ  = 4'b0010,
        K_STOP  = 4'b0100,
        K_NONE  = 4'b1000
    } t_kind;

    // one queued operation, already reduced to what the sequencer needs
    typedef struct packed {
        t_kind              kind;
        logic               start;
        logic [BYTES_W-1:0] nbytes_m1;
        logic [ADDR_W-1:0]  data;
        logic [7:0]         lines;
        logic               ack;
        logic               nak;
        logic [1:0]         status;
    } t_desc;

endpackage
`default_nettype wire

// ===== hw/rtl/i2cbe_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cbe_front
// accepts operations, keeps configuration and the command attempt count,
// and turns each operation into a sequencer descriptor
// ----------------------------------------------------------------------------
module i2cbe_front
    import i2cbe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_op,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic [ADDR_W-1:0] i_target_address,
    input  wire logic [7:0]  i_line_bits,
    input  wire logic        i_ack_line,
    output logic             o_push,
    input  wire logic        i_push_ready,
    output t_desc            o_desc
);

    logic [7:0] r_retry_limit;
    logic [2:0] r_address_bytes;
    logic [8:0] r_attempt;
    logic [8:0] n_attempt;
    logic [1:0] cmd_status;
    logic [2:0] seek_cnt;
    logic       accept;

    assign o_ready = i_push_ready;
    assign o_push = i_valid;
    assign accept = i_valid && i_push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= '0;
            r_address_bytes <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RETRY_LIMIT: r_retry_limit <= i_cfg_data;
                REG_ADDRESS_BYTES: r_address_bytes <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // command attempt bookkeeping
    always_comb begin
        if (r_attempt > {1'b0, r_retry_limit}) begin
            cmd_status = STAT_TIMEOUT;
            n_attempt = '0;
        end else if (i_ack_line) begin
            cmd_status = STAT_NAK;
            n_attempt = r_attempt + 9'd1;
        end else begin
            cmd_status = STAT_OK;
            n_attempt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attempt <= '0;
        end else if (accept && i_op == OP_COMMAND) begin
            r_attempt <= n_attempt;
        end
    end

    assign seek_cnt = (r_address_bytes > 3'(MAX_ADDRESS_BYTES))
                      ? 3'(MAX_ADDRESS_BYTES) : r_address_bytes;

    always_comb begin
        o_desc = '0;
        o_desc.kind = K_NONE;
        o_desc.lines = i_line_bits;
        o_desc.ack = i_ack_line;
        o_desc.nak = (i_op == OP_READ_NAK);
        case (i_op)
            OP_COMMAND: begin
                o_desc.kind = K_BYTES;
                o_desc.start = 1'b1;
                o_desc.data = {i_byte_value, 24'd0};
                o_desc.status = cmd_status;
            end
            OP_WRITE: begin
                o_desc.kind = K_BYTES;
                o_desc.data = {i_byte_value, 24'd0};
            end
            OP_READ_ACK, OP_READ_NAK: begin
                o_desc.kind = K_READ;
            end
            OP_STOP: begin
                o_desc.kind = K_STOP;
            end
            OP_SEEK: begin
                // left-align the address bytes that go out, msb first
                case (seek_cnt)
                    3'd1: begin
                        o_desc.kind = K_BYTES;
                        o_desc.data = i_target_address << 24;
                    end
                    3'd2: begin
                        o_desc.kind = K_BYTES;
                        o_desc.data = i_target_address << 16;
                    end
                    3'd3: begin
                        o_desc.kind = K_BYTES;
                        o_desc.data = i_target_address << 8;
                    end
                    3'd4: begin
                        o_desc.kind = K_BYTES;
                        o_desc.data = i_target_address;
                    end
                    default: begin
                        o_desc.kind = K_NONE;
                        o_desc.status = STAT_OK;
                    end
                endcase
                o_desc.nbytes_m1 = BYTES_W'(seek_cnt - 3'd1);
            end
            default: begin
                o_desc.kind = K_NONE;
                o_desc.status = STAT_INVALID;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/i2cbe_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cbe_queue
// two-entry descriptor queue between front and sequencer
// ----------------------------------------------------------------------------
module i2cbe_queue
    import i2cbe_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    output logic       o_push_ready,
    input  wire t_desc i_desc,
    output logic       o_valid,
    input  wire logic  i_pop,
    output t_desc      o_desc
);

    t_desc      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_desc = r_mem[r_rd];
    assign do_push = i_push && o_push_ready;
    assign do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            case ({do_push, do_pop})
                2'b10: r_count <= r_count + 2'd1;
                2'b01: r_count <= r_count - 2'd1;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/i2cbe_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cbe_back
// symbol sequencer: walks one descriptor a symbol per cycle, unless the output
// stalls, into the output register
// ----------------------------------------------------------------------------
module i2cbe_back
    import i2cbe_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_desc i_desc,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic [2:0] o_symbol,
    output logic       o_bit_value,
    output logic       o_last,
    output logic [7:0] o_read_data,
    output logic       o_ack_seen,
    output logic [1:0] o_status
);

    t_desc              r_cur;
    logic               r_cur_valid;
    logic               r_start;
    logic [3:0]         r_cnt;
    logic [BYTES_W-1:0] r_left;
    logic [ADDR_W-1:0]  r_sh;

    logic       r_out_valid;
    logic [2:0] r_sym;
    logic       r_bit;
    logic       r_last;
    logic [7:0] r_rd;
    logic       r_ack;
    logic [1:0] r_st;

    logic [2:0] sym;
    logic       bitv;
    logic       last;
    logic [7:0] rd;
    logic       ack;
    logic [1:0] st;
    logic       adv;
    logic       fin;
    logic       load;

    always_comb begin
        sym = SYM_NONE;
        bitv = 1'b0;
        last = 1'b0;
        rd = '0;
        ack = 1'b0;
        st = STAT_OK;
        case (r_cur.kind)
            K_BYTES: begin
                if (r_start) begin
                    sym = SYM_START;
                end else if (r_cnt == ACK_SLOT) begin
                    sym = SYM_SAMPLE;
                    ack = r_cur.ack;
                    last = (r_left == '0);
                    st = last ? r_cur.status : STAT_OK;
                end else begin
                    sym = SYM_DRIVE;
                    bitv = r_sh[ADDR_W-1];
                end
            end
            K_READ: begin
                if (r_cnt == ACK_SLOT) begin
                    sym = SYM_DRIVE;
                    bitv = r_cur.nak;
                    last = 1'b1;
                    rd = r_cur.lines;
                end else begin
                    sym = SYM_SAMPLE;
                end
            end
            K_STOP: begin
                sym = SYM_STOP;
                last = 1'b1;
            end
            default: begin
                sym = SYM_NONE;
                last = 1'b1;
                st = r_cur.status;
            end
        endcase
    end

    assign adv = r_cur_valid && (!r_out_valid || i_ready);
    assign fin = adv && last;
    assign load = i_valid && (!r_cur_valid || fin);
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_desc;
            r_start <= i_desc.start;
            r_cnt <= '0;
            r_left <= i_desc.nbytes_m1;
            r_sh <= i_desc.data;
        end else if (adv) begin
            if (r_start) begin
                r_start <= 1'b0;
            end else if (r_cnt == ACK_SLOT) begin
                r_cnt <= '0;
                r_left <= r_left - BYTES_W'(1);
            end else begin
                r_cnt <= r_cnt + 4'd1;
                r_sh <= r_sh << 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_cur_valid <= 1'b1;
            end else if (fin) begin
                r_cur_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sym <= sym;
            r_bit <= bitv;
            r_last <= last;
            r_rd <= rd;
            r_ack <= ack;
            r_st <= st;
        end
    end

    assign o_valid = r_out_valid;
    assign o_symbol = r_sym;
    assign o_bit_value = r_bit;
    assign o_last = r_last;
    assign o_read_data = r_rd;
    assign o_ack_seen = r_ack;
    assign o_status = r_st;

endmodule
`default_nettype wire

// ===== hw/rtl/i2c_master_byte_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// i2c master at bus-symbol level: one request in, a run of bus symbols out
//
//   channel   direction  contents
//   s_axis    in         op, byte_value, target_address, line_bits, ack_line
//   m_axis    out        symbol, bit_value, read_data, ack_seen, status; last
//   cfg       in         retry_limit (0), address_bytes (1)
//
// the sequencer sets the pace, one symbol per cycle unless the output stalls;
// a byte is eight bits and an ack, a command adds a start, a seek a byte per
// address byte, stop and single-symbol requests one symbol; the front takes a
// request whenever the two-entry queue has room; requests run gap-free
// reset clears the attempt count, configuration, queue and output register
// output stalls hold the sequencer, input stalls only starve it
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
    import i2cbe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // op[2:0], byte_value[10:3], target_address[42:11], line_bits[50:43],
    // ack_line[51], zero fill
    input  wire logic [55:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // symbol[2:0], bit_value[3], read_data[11:4], ack_seen[12], status[14:13],
    // zero fill
    output logic [15:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    logic       push;
    logic       push_ready;
    t_desc      front_desc;
    logic       q_valid;
    logic       pop;
    t_desc      q_desc;
    logic [2:0] symbol;
    logic       bit_value;
    logic [7:0] read_data;
    logic       ack_seen;
    logic [1:0] status;

    i2cbe_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_op             (s_axis_tdata[2:0]),
        .i_byte_value     (s_axis_tdata[10:3]),
        .i_target_address (s_axis_tdata[42:11]),
        .i_line_bits      (s_axis_tdata[50:43]),
        .i_ack_line       (s_axis_tdata[51]),
        .o_push           (push),
        .i_push_ready     (push_ready),
        .o_desc           (front_desc)
    );

    i2cbe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_desc       (front_desc),
        .o_valid      (q_valid),
        .i_pop        (pop),
        .o_desc       (q_desc)
    );

    i2cbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_desc      (q_desc),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_symbol    (symbol),
        .o_bit_value (bit_value),
        .o_last      (m_axis_tlast),
        .o_read_data (read_data),
        .o_ack_seen  (ack_seen),
        .o_status    (status)
    );

    assign m_axis_tdata = {1'b0, status, ack_seen, read_data, bit_value, symbol};

endmodule
`default_nettype wire
